// ===== rtl/core/segx_pkg.sv =====
// Shared constant and control type for the segment intersection block.
package segx_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Control that rides along each divider cell.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } segx_ctl_t;

endpackage

// ===== rtl/core/segx_cell.sv =====
// One restoring-division cell: settles one quotient bit for both coordinates.
module segx_cell
    import segx_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SHIFT      = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  segx_ctl_t                   ctl_in,
    input  logic [COORD_BITS-1:0]       px_in,
    input  logic [COORD_BITS-1:0]       py_in,
    input  logic [2*COORD_BITS+1:0]     dv_in,
    input  logic [3*COORD_BITS+2:0]     rem_x_in,
    input  logic [3*COORD_BITS+2:0]     rem_y_in,
    input  logic [COORD_BITS:0]         q_x_in,
    input  logic [COORD_BITS:0]         q_y_in,
    output segx_ctl_t                   ctl_out,
    output logic [COORD_BITS-1:0]       px_out,
    output logic [COORD_BITS-1:0]       py_out,
    output logic [2*COORD_BITS+1:0]     dv_out,
    output logic [3*COORD_BITS+2:0]     rem_x_out,
    output logic [3*COORD_BITS+2:0]     rem_y_out,
    output logic [COORD_BITS:0]         q_x_out,
    output logic [COORD_BITS:0]         q_y_out
);

    localparam int NUMW = 3*COORD_BITS + 3;

    logic [NUMW-1:0] dsh;
    logic            ge_x;
    logic            ge_y;
    segx_ctl_t       ctl_reg;

    assign dsh  = NUMW'(dv_in) << SHIFT;
    assign ge_x = rem_x_in >= dsh;
    assign ge_y = rem_y_in >= dsh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_out    <= px_in;
            py_out    <= py_in;
            dv_out    <= dv_in;
            rem_x_out <= ge_x ? rem_x_in - dsh : rem_x_in;
            rem_y_out <= ge_y ? rem_y_in - dsh : rem_y_in;
            q_x_out   <= {q_x_in[COORD_BITS-1:0], ge_x};
            q_y_out   <= {q_y_in[COORD_BITS-1:0], ge_y};
        end
    end

    assign ctl_out = ctl_reg;

endmodule

// ===== rtl/core/segment_intersection.sv =====
// Top level of the segment intersection block: front end, divider chain, output register.
//
// Each input word holds two segments A and B. The block forms the cross products of the
// segment directions, decides exactly (rational compare, no rounding) whether the segments
// meet at a single point, and if so returns that point as A's start plus the offset along A,
// truncated toward zero; otherwise hit is 0 and both coordinates are 0. Parallel, collinear and zero-length
// segments never report a hit. A new word can be accepted on every clock cycle unless the pipeline holds.
// From acceptance to a valid result a word passes six front-end stages (differences,
// products, cross sums, sign normalization and hit test, two partial products, their sum),
// one cell per quotient bit in the divider chain (COORD_BITS + 1 cells), and the output
// register. The whole pipeline advances together and holds only while a finished result
// sits in the output register and is not being taken, so s_ready depends on m_ready.
module segment_intersection
    import segx_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_a_start_x,
    input  logic signed [COORD_BITS-1:0] s_a_start_y,
    input  logic signed [COORD_BITS-1:0] s_a_end_x,
    input  logic signed [COORD_BITS-1:0] s_a_end_y,
    input  logic signed [COORD_BITS-1:0] s_b_start_x,
    input  logic signed [COORD_BITS-1:0] s_b_start_y,
    input  logic signed [COORD_BITS-1:0] s_b_end_x,
    input  logic signed [COORD_BITS-1:0] s_b_end_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic signed [COORD_BITS-1:0] m_cross_x,
    output logic signed [COORD_BITS-1:0] m_cross_y
);

    localparam int N     = COORD_BITS;
    localparam int DW    = N + 1;       // coordinate differences
    localparam int PW    = 2*N + 2;     // products, |d|, normalized tn
    localparam int CW    = 2*N + 3;     // cross values before normalization
    localparam int MW    = N + 1;       // magnitudes and quotients
    localparam int NUMW  = 3*N + 3;     // dividend
    localparam int CELLS = N + 1;

    // The whole pipeline moves when the output register is free or being emptied.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage A: coordinate differences.
    logic                 a_valid_reg;
    logic [N-1:0]         a_px_reg, a_py_reg;
    logic signed [DW-1:0] a_rx_reg, a_ry_reg, a_qx_reg, a_qy_reg, a_sx_reg, a_sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_px_reg <= s_a_start_x;
            a_py_reg <= s_a_start_y;
            a_rx_reg <= DW'(s_a_end_x) - DW'(s_a_start_x);
            a_ry_reg <= DW'(s_a_end_y) - DW'(s_a_start_y);
            a_qx_reg <= DW'(s_b_start_x) - DW'(s_a_start_x);
            a_qy_reg <= DW'(s_b_start_y) - DW'(s_a_start_y);
            a_sx_reg <= DW'(s_b_end_x) - DW'(s_b_start_x);
            a_sy_reg <= DW'(s_b_end_y) - DW'(s_b_start_y);
        end
    end

    // Stage B: the six products of the three cross products.
    logic                 b_valid_reg;
    logic [N-1:0]         b_px_reg, b_py_reg;
    logic signed [DW-1:0] b_rx_reg, b_ry_reg;
    logic signed [PW-1:0] b_d1_reg, b_d2_reg, b_t1_reg, b_t2_reg, b_u1_reg, b_u2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_px_reg <= a_px_reg;
            b_py_reg <= a_py_reg;
            b_rx_reg <= a_rx_reg;
            b_ry_reg <= a_ry_reg;
            b_d1_reg <= PW'(a_rx_reg) * PW'(a_sy_reg);
            b_d2_reg <= PW'(a_ry_reg) * PW'(a_sx_reg);
            b_t1_reg <= PW'(a_qx_reg) * PW'(a_sy_reg);
            b_t2_reg <= PW'(a_qy_reg) * PW'(a_sx_reg);
            b_u1_reg <= PW'(a_qx_reg) * PW'(a_ry_reg);
            b_u2_reg <= PW'(a_qy_reg) * PW'(a_rx_reg);
        end
    end

    // Stage C: denominator d and the two numerators.
    logic                 c_valid_reg;
    logic [N-1:0]         c_px_reg, c_py_reg;
    logic signed [DW-1:0] c_rx_reg, c_ry_reg;
    logic signed [CW-1:0] c_d_reg, c_tn_reg, c_un_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_px_reg <= b_px_reg;
            c_py_reg <= b_py_reg;
            c_rx_reg <= b_rx_reg;
            c_ry_reg <= b_ry_reg;
            c_d_reg  <= CW'(b_d1_reg) - CW'(b_d2_reg);
            c_tn_reg <= CW'(b_t1_reg) - CW'(b_t2_reg);
            c_un_reg <= CW'(b_u1_reg) - CW'(b_u2_reg);
        end
    end

    // Stage D: make d positive, test both parameters against [0,1].
    logic                 neg_d;
    logic signed [CW-1:0] d_abs, tn_n, un_n;
    logic                 hit_c;

    assign neg_d = c_d_reg[CW-1];
    assign d_abs = neg_d ? -c_d_reg  : c_d_reg;
    assign tn_n  = neg_d ? -c_tn_reg : c_tn_reg;
    assign un_n  = neg_d ? -c_un_reg : c_un_reg;
    assign hit_c = (c_d_reg != '0) && !tn_n[CW-1] && (tn_n <= d_abs)
                   && !un_n[CW-1] && (un_n <= d_abs);

    logic            d_valid_reg, d_hit_reg, d_negx_reg, d_negy_reg;
    logic [N-1:0]    d_px_reg, d_py_reg;
    logic [PW-1:0]   d_dv_reg, d_tn_reg;
    logic [MW-1:0]   d_magx_reg, d_magy_reg;
    logic signed [DW-1:0] abs_rx, abs_ry;

    assign abs_rx = c_rx_reg[DW-1] ? -c_rx_reg : c_rx_reg;
    assign abs_ry = c_ry_reg[DW-1] ? -c_ry_reg : c_ry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            d_hit_reg   <= 1'b0;
            d_negx_reg  <= 1'b0;
            d_negy_reg  <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
            d_hit_reg   <= hit_c;
            d_negx_reg  <= c_rx_reg[DW-1];
            d_negy_reg  <= c_ry_reg[DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_px_reg   <= c_px_reg;
            d_py_reg   <= c_py_reg;
            d_dv_reg   <= d_abs[PW-1:0];
            d_tn_reg   <= tn_n[PW-1:0];
            d_magx_reg <= abs_rx[MW-1:0];
            d_magy_reg <= abs_ry[MW-1:0];
        end
    end

    // Stage E: tn times |r| as two narrow partial products per coordinate.
    segx_ctl_t       e_ctl_reg;
    logic [N-1:0]    e_px_reg, e_py_reg;
    logic [PW-1:0]   e_dv_reg;
    logic [2*MW-1:0] e_lox_reg, e_hix_reg, e_loy_reg, e_hiy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_ctl_reg <= '0;
        end else if (en) begin
            e_ctl_reg <= '{valid: d_valid_reg, hit: d_hit_reg,
                           neg_x: d_negx_reg, neg_y: d_negy_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_px_reg  <= d_px_reg;
            e_py_reg  <= d_py_reg;
            e_dv_reg  <= d_dv_reg;
            e_lox_reg <= (2*MW)'(d_tn_reg[MW-1:0])  * (2*MW)'(d_magx_reg);
            e_hix_reg <= (2*MW)'(d_tn_reg[PW-1:MW]) * (2*MW)'(d_magx_reg);
            e_loy_reg <= (2*MW)'(d_tn_reg[MW-1:0])  * (2*MW)'(d_magy_reg);
            e_hiy_reg <= (2*MW)'(d_tn_reg[PW-1:MW]) * (2*MW)'(d_magy_reg);
        end
    end

    // Stage F feeds the divider chain; index 0 of the chain arrays is this stage.
    segx_ctl_t       ch_ctl  [CELLS+1];
    logic [N-1:0]    ch_px   [CELLS+1];
    logic [N-1:0]    ch_py   [CELLS+1];
    logic [PW-1:0]   ch_dv   [CELLS+1];
    logic [NUMW-1:0] ch_remx [CELLS+1];
    logic [NUMW-1:0] ch_remy [CELLS+1];
    logic [MW-1:0]   ch_qx   [CELLS+1];
    logic [MW-1:0]   ch_qy   [CELLS+1];

    segx_ctl_t       f_ctl_reg;
    logic [N-1:0]    f_px_reg, f_py_reg;
    logic [PW-1:0]   f_dv_reg;
    logic [NUMW-1:0] f_numx_reg, f_numy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_ctl_reg <= '0;
        end else if (en) begin
            f_ctl_reg <= e_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_px_reg   <= e_px_reg;
            f_py_reg   <= e_py_reg;
            f_dv_reg   <= e_dv_reg;
            f_numx_reg <= (NUMW'(e_hix_reg) << MW) + NUMW'(e_lox_reg);
            f_numy_reg <= (NUMW'(e_hiy_reg) << MW) + NUMW'(e_loy_reg);
        end
    end

    assign ch_ctl[0]  = f_ctl_reg;
    assign ch_px[0]   = f_px_reg;
    assign ch_py[0]   = f_py_reg;
    assign ch_dv[0]   = f_dv_reg;
    assign ch_remx[0] = f_numx_reg;
    assign ch_remy[0] = f_numy_reg;
    assign ch_qx[0]   = '0;
    assign ch_qy[0]   = '0;

    // Divider chain: cell i settles quotient bit N - i.
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        segx_cell #(
            .COORD_BITS (COORD_BITS),
            .SHIFT      (N - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .ctl_in    (ch_ctl[i]),
            .px_in     (ch_px[i]),
            .py_in     (ch_py[i]),
            .dv_in     (ch_dv[i]),
            .rem_x_in  (ch_remx[i]),
            .rem_y_in  (ch_remy[i]),
            .q_x_in    (ch_qx[i]),
            .q_y_in    (ch_qy[i]),
            .ctl_out   (ch_ctl[i+1]),
            .px_out    (ch_px[i+1]),
            .py_out    (ch_py[i+1]),
            .dv_out    (ch_dv[i+1]),
            .rem_x_out (ch_remx[i+1]),
            .rem_y_out (ch_remy[i+1]),
            .q_x_out   (ch_qx[i+1]),
            .q_y_out   (ch_qy[i+1])
        );
    end

    // Output register: apply the sign of r, add the start point, zero on a miss.
    segx_ctl_t    last_ctl;
    logic [N-1:0] res_x, res_y;
    logic [MW-1:0] qx_s, qy_s;

    assign last_ctl = ch_ctl[CELLS];
    assign qx_s  = last_ctl.neg_x ? -ch_qx[CELLS] : ch_qx[CELLS];
    assign qy_s  = last_ctl.neg_y ? -ch_qy[CELLS] : ch_qy[CELLS];
    assign res_x = ch_px[CELLS] + qx_s[N-1:0];
    assign res_y = ch_py[CELLS] + qy_s[N-1:0];

    logic         m_valid_reg, m_hit_reg;
    logic [N-1:0] m_x_reg, m_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= last_ctl.hit;
            m_x_reg   <= last_ctl.hit ? res_x : '0;
            m_y_reg   <= last_ctl.hit ? res_y : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_cross_x = m_x_reg;
    assign m_cross_y = m_y_reg;

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_cross_x == '0 && m_cross_y == '0)
        else $error("missed intersection carries a nonzero point");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present right after reset");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(f_ctl_reg) && $stable(m_valid_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== tb/tb_segment_intersection.sv =====
// Testbench for the segment intersection block: directed and random segment pairs.
module tb_segment_intersection;
    timeunit 1ns;
    timeprecision 1ps;
    import segx_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int LATENCY = CB + 8;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;

    // One segment pair as it travels on the input channel.
    typedef struct {
        coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    // One intersection result as it appears on the result channel.
    typedef struct {
        logic   hit;
        coord_t x, y;
    } crossing_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_a_start_x = '0, s_a_start_y = '0, s_a_end_x = '0, s_a_end_y = '0;
    coord_t s_b_start_x = '0, s_b_start_y = '0, s_b_end_x = '0, s_b_end_y = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit;
    coord_t m_cross_x, m_cross_y;

    crossing_t expected_crossings[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    segment_intersection #(.COORD_BITS(CB)) dut (.*);

    always #4 aclk = ~aclk;

    // Exact prediction. All products fit in 64 bits for 16-bit coordinates; the
    // scaled product t*r needs up to about 50 bits, so longint is enough.
    function automatic crossing_t predict_crossing(seg_pair_t p);
        longint px, py, rx, ry, qx, qy, sx, sy, d, tn, un, mx, my, qtx, qty;
        crossing_t c;
        px = p.ax0; py = p.ay0;
        rx = longint'(p.ax1) - px; ry = longint'(p.ay1) - py;
        qx = longint'(p.bx0) - px; qy = longint'(p.by0) - py;
        sx = longint'(p.bx1) - p.bx0; sy = longint'(p.by1) - p.by0;
        d  = rx * sy - ry * sx;
        tn = qx * sy - qy * sx;
        un = qx * ry - qy * rx;
        c.hit = 1'b0; c.x = '0; c.y = '0;
        if (d == 0) return c;
        if (d < 0) begin
            d = -d; tn = -tn; un = -un;
        end
        if (tn < 0 || tn > d || un < 0 || un > d) return c;
        // Truncate toward zero on the magnitude, then restore the sign.
        mx = rx < 0 ? -rx : rx;
        my = ry < 0 ? -ry : ry;
        qtx = (tn * mx) / d;
        qty = (tn * my) / d;
        if (rx < 0) qtx = -qtx;
        if (ry < 0) qty = -qty;
        c.hit = 1'b1;
        c.x = coord_t'(px + qtx);
        c.y = coord_t'(py + qty);
        return c;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Sends one word, idling first at the current rate, and queues its prediction.
    // Valid stays high after acceptance until the next word or an idle cycle replaces it.
    task automatic send_pair(seg_pair_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_a_start_x <= p.ax0; s_a_start_y <= p.ay0;
        s_a_end_x   <= p.ax1; s_a_end_y   <= p.ay1;
        s_b_start_x <= p.bx0; s_b_start_y <= p.by0;
        s_b_end_x   <= p.bx1; s_b_end_y   <= p.by1;
        do @(posedge aclk); while (!s_ready);
        expected_crossings.push_back(predict_crossing(p));
    endtask

    function automatic seg_pair_t make_pair(int a0, int a1, int a2, int a3,
                                            int b0, int b1, int b2, int b3);
        seg_pair_t p;
        p.ax0 = coord_t'(a0); p.ay0 = coord_t'(a1); p.ax1 = coord_t'(a2); p.ay1 = coord_t'(a3);
        p.bx0 = coord_t'(b0); p.by0 = coord_t'(b1); p.bx1 = coord_t'(b2); p.by1 = coord_t'(b3);
        return p;
    endfunction

    function automatic coord_t rand_coord(int span);
        if (span == 0) return coord_t'($urandom);
        return coord_t'($urandom_range(2 * span) - span);
    endfunction

    // A pair that crosses with high probability: B is built around a point on A.
    function automatic seg_pair_t rand_crossing_pair(int span);
        seg_pair_t p;
        longint ax0, ay0, ax1, ay1, mx, my, dx, dy;
        p.ax0 = rand_coord(span); p.ay0 = rand_coord(span);
        p.ax1 = rand_coord(span); p.ay1 = rand_coord(span);
        ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
        mx = (ax0 + ax1) / 2; my = (ay0 + ay1) / 2;
        dx = $urandom_range(2000) - 1000; dy = $urandom_range(2000) - 1000;
        p.bx0 = coord_t'(mx - dx); p.by0 = coord_t'(my - dy);
        p.bx1 = coord_t'(mx + dx); p.by1 = coord_t'(my + dy);
        return p;
    endfunction

    // The receiver stalls at random; every accepted word is checked against the oldest
    // prediction.
    always @(posedge aclk) begin
        crossing_t e;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_crossings.size() == 0) begin
                report_mismatch("result word with no prediction waiting");
            end else begin
                e = expected_crossings.pop_front();
                if (m_hit !== e.hit)
                    report_mismatch($sformatf("hit %b expected %b", m_hit, e.hit));
                if (m_cross_x !== e.x)
                    report_mismatch($sformatf("cross_x %0d expected %0d", m_cross_x, e.x));
                if (m_cross_y !== e.y)
                    report_mismatch($sformatf("cross_y %0d expected %0d", m_cross_y, e.y));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_segment_intersection failed");
            $finish;
        end
    end

    // Drops valid, then waits until every queued prediction has been matched.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_crossings.size() != 0) @(posedge aclk);
    endtask

    // Extremes, parallel and collinear cases, zero-length segments, ends touching.
    task automatic test_directed();
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
        send_pair(make_pair(0, 0, 10, 0, 20, 0, 30, 0));
        send_pair(make_pair(3, 3, 3, 3, 0, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 10, 4, 4, 4, 4));
        send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, -10));
        send_pair(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 10));
        send_pair(make_pair(0, 0, 7, 3, 0, 3, 7, 0));
        send_pair(make_pair(0, 0, -7, -3, 0, -3, -7, 0));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_pair(make_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 1));
        send_pair(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(make_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_pair(make_pair(0, 0, 1, 1, 1, 0, 0, 1));
    endtask

    task automatic test_random(int count, int idle, int stall);
        int span;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) begin
            span = ($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 100 : 30000);
            if ($urandom_range(9) < 7) send_pair(rand_crossing_pair(span));
            else send_pair(make_pair($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    // The sender holds off until the pipeline is empty, then restarts.
    task automatic test_drain_pause();
        wait_drained();
        repeat (LATENCY) @(posedge aclk);
        test_random(20, 0, 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(220, 0, 0);
        test_random(220, 70, 0);
        test_drain_pause();
        test_random(220, 0, 70);
        test_random(220, 11, 11);
        wait_drained();
        repeat (LATENCY + 4) @(posedge aclk);
        if (error_count == 0 && expected_crossings.size() == 0) begin
            $display("tb_segment_intersection passed");
        end else begin
            $display("tb_segment_intersection failed");
        end
        $finish;
    end
endmodule
